// File: sv/wheel_speed_period_meter_defines.svh
// assertion macros used by the checker file
`ifndef WHEEL_SPEED_PERIOD_METER_DEFINES_SVH
`define WHEEL_SPEED_PERIOD_METER_DEFINES_SVH

// same-cycle implication, checked at the rising clock edge
`define WSP_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("wsp check failed");

// next-cycle implication, checked at the rising clock edge
`define WSP_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("wsp check failed");

`endif

// File: sv/wsp_pkg.sv
package wsp_pkg;

    // field and register widths
    localparam int CAP_W       = 32;
    localparam int SPEED_W     = 48;
    localparam int SCALE_W     = 32;
    localparam int LIMIT_W     = 8;
    localparam int COUNT_W     = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // parameter defaults
    localparam int WHEELS_DEF    = 2;
    localparam int FRAC_BITS_DEF = 16;

    // limits and reset values
    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;

    // input opcodes
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPEED_SCALE = 2'd0,
        REG_STALE_LIMIT = 2'd1
    } cfg_reg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_SPEED,
        ST_EMIT
    } state_t;

    // input transaction payload
    typedef struct packed {
        logic             opcode;
        logic             wheel;
        logic [CAP_W-1:0] capture_value;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic               speed_wheel;
        logic [SPEED_W-1:0] speed;
        logic               last_of_run;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic cap_we;
        logic rd_start;
        logic setup;
        logic div_step;
        logic speed_load;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
        logic last_wheel;
    } sts_t;

endpackage

// File: sv/wsp_ctrl.sv
module wsp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_opcode,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output wsp_pkg::cmd_t cmd,
    input  wsp_pkg::sts_t sts
);

    wsp_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wsp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_free   = !m_valid_reg || m_ready;
        unique case (state_reg)
            wsp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == wsp_pkg::OP_READ) begin
                        cmd.rd_start = 1'b1;
                        state_next   = wsp_pkg::ST_SETUP;
                    end else begin
                        cmd.cap_we = 1'b1;
                    end
                end
            end
            wsp_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = wsp_pkg::ST_DIV;
            end
            wsp_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = wsp_pkg::ST_SPEED;
                end
            end
            wsp_pkg::ST_SPEED: begin
                cmd.speed_load = 1'b1;
                state_next     = wsp_pkg::ST_EMIT;
            end
            wsp_pkg::ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_wheel ? wsp_pkg::ST_IDLE : wsp_pkg::ST_SETUP;
                end
            end
            default: begin
                state_next = wsp_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid: set on emit, cleared when taken
    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sv/wsp_datapath.sv
module wsp_datapath #(
    parameter int WHEELS    = wsp_pkg::WHEELS_DEF,
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [wsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wsp_pkg::in_item_t                s_data,
    output wsp_pkg::out_item_t               m_data,
    input  wsp_pkg::cmd_t                    cmd,
    output wsp_pkg::sts_t                    sts
);

    localparam int IDX_W  = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int NUM_W  = wsp_pkg::SCALE_W + FRAC_BITS;
    localparam int QW     = (NUM_W > wsp_pkg::SPEED_W) ? NUM_W : wsp_pkg::SPEED_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    // configuration registers
    logic [wsp_pkg::SCALE_W-1:0] scale_reg;
    logic [wsp_pkg::LIMIT_W-1:0] limit_reg;

    // per-wheel state
    logic [wsp_pkg::CAP_W-1:0]   first_cap_reg  [WHEELS];
    logic [wsp_pkg::CAP_W-1:0]   second_cap_reg [WHEELS];
    logic                        phase_reg      [WHEELS];
    logic [wsp_pkg::SPEED_W-1:0] prev_speed_reg [WHEELS];
    logic [wsp_pkg::COUNT_W-1:0] rep_count_reg  [WHEELS];

    // divider and result state
    logic [IDX_W-1:0]            idx_reg;
    logic [wsp_pkg::CAP_W-1:0]   diff_reg;
    logic                        zero_reg;
    logic                        equal_reg;
    logic [wsp_pkg::CAP_W-1:0]   rem_reg;
    logic [NUM_W-1:0]            quo_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [wsp_pkg::SPEED_W-1:0] speed_reg;
    wsp_pkg::out_item_t          out_reg;

    logic [IDX_W-1:0]            cap_idx;
    logic                        cap_ok;
    logic [wsp_pkg::CAP_W-1:0]   cap_a, cap_b, diff_next;
    logic [wsp_pkg::CAP_W:0]     rem_sh, rem_sub;
    logic                        rem_ge;
    logic [QW-1:0]               quo_ext;
    logic [wsp_pkg::SPEED_W-1:0] speed_next;
    logic                        match;
    logic [wsp_pkg::COUNT_W-1:0] cnt_cur, rep_count_next;
    logic                        stale;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= wsp_pkg::SCALE_RESET;
            limit_reg <= wsp_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wsp_pkg::REG_SPEED_SCALE: scale_reg <= cfg_wdata[wsp_pkg::SCALE_W-1:0];
                wsp_pkg::REG_STALE_LIMIT: limit_reg <= cfg_wdata[wsp_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture target wheel
    assign cap_idx = IDX_W'(s_data.wheel);
    assign cap_ok  = (32'(s_data.wheel) < WHEELS);

    // captures alternate between first and second store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < WHEELS; w++) begin
                first_cap_reg[w]  <= '0;
                second_cap_reg[w] <= '0;
                phase_reg[w]      <= 1'b0;
            end
        end else if (cmd.cap_we && cap_ok) begin
            if (!phase_reg[cap_idx]) begin
                first_cap_reg[cap_idx] <= s_data.capture_value;
            end else begin
                second_cap_reg[cap_idx] <= s_data.capture_value;
            end
            phase_reg[cap_idx] <= !phase_reg[cap_idx];
        end
    end

    // wheel counter for a read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.rd_start) begin
            idx_reg <= '0;
        end else if (cmd.emit && !sts.last_wheel) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // absolute capture difference
    assign cap_a     = first_cap_reg[idx_reg];
    assign cap_b     = second_cap_reg[idx_reg];
    assign diff_next = (cap_a > cap_b) ? (cap_a - cap_b) : (cap_b - cap_a);

    // restoring divider step, one quotient bit per cycle
    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, diff_reg});
    assign rem_sub = rem_sh - {1'b0, diff_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.setup) begin
            step_reg <= STEP_W'(NUM_W);
        end else if (cmd.div_step) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            diff_reg  <= diff_next;
            zero_reg  <= (cap_a == '0) || (cap_b == '0);
            equal_reg <= (diff_next == '0);
            rem_reg   <= '0;
            quo_reg   <= NUM_W'(scale_reg) << FRAC_BITS;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sub[wsp_pkg::CAP_W-1:0] : rem_sh[wsp_pkg::CAP_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
        end
    end

    // special cases and saturation of the quotient
    assign quo_ext = QW'(quo_reg);
    always_comb begin
        if (zero_reg) begin
            speed_next = '0;
        end else if (equal_reg || (quo_ext > QW'(wsp_pkg::SPEED_MAX))) begin
            speed_next = wsp_pkg::SPEED_MAX;
        end else begin
            speed_next = quo_ext[wsp_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.speed_load) begin
            speed_reg <= speed_next;
        end
    end

    // repeat tracking and stale suppression
    assign cnt_cur = rep_count_reg[idx_reg];
    assign match   = (speed_reg == prev_speed_reg[idx_reg]);
    always_comb begin
        if (!match) begin
            rep_count_next = '0;
        end else if (cnt_cur == wsp_pkg::COUNT_MAX) begin
            rep_count_next = cnt_cur;
        end else begin
            rep_count_next = cnt_cur + 1'b1;
        end
    end
    assign stale = match && (rep_count_next > limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < WHEELS; w++) begin
                prev_speed_reg[w] <= '0;
                rep_count_reg[w]  <= '0;
            end
        end else if (cmd.emit) begin
            prev_speed_reg[idx_reg] <= speed_reg;
            rep_count_reg[idx_reg]  <= rep_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.speed_wheel <= idx_reg[0];
            out_reg.speed       <= stale ? '0 : speed_reg;
            out_reg.last_of_run <= sts.last_wheel;
        end
    end

    assign m_data         = out_reg;
    assign sts.div_last   = (step_reg == STEP_W'(1));
    assign sts.last_wheel = (idx_reg == IDX_W'(WHEELS - 1));

endmodule

// File: sv/wheel_speed_period_meter.sv
// capture transaction: block stays idle and is ready again on the next cycle
// read transaction: for each wheel in turn, setup, then the radix-2 restoring divider
// producing one quotient bit per cycle, then speed load and result emit; emit waits
// while a result is stalled, and the next input is taken only after the last wheel's
// result is emitted
// reset: synchronous, active low; clears all captures, repeat state and restores config
module wheel_speed_period_meter #(
    parameter int WHEELS    = wsp_pkg::WHEELS_DEF,
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [wsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wsp_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wsp_pkg::out_item_t              m_data
);

    wsp_pkg::cmd_t cmd;
    wsp_pkg::sts_t sts;

    // sequencing
    wsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_data.opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // state, divider and result register
    wsp_datapath #(
        .WHEELS    (WHEELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: sv/wsp_checker.sv
`include "wheel_speed_period_meter_defines.svh"

module wsp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input wsp_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input wsp_pkg::out_item_t m_data
);

    // a stalled result holds
    `WSP_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // after a capture transaction the block is ready again in the next cycle
    `WSP_ASSERT_NEXT(a_cap_quick, aclk, !aresetn,
        s_valid && s_ready && (s_data.opcode == wsp_pkg::OP_CAPTURE), s_ready)

    // a read transaction makes the block busy
    `WSP_ASSERT_NEXT(a_read_busy, aclk, !aresetn,
        s_valid && s_ready && (s_data.opcode == wsp_pkg::OP_READ), !s_ready)

    // no input taken while results of a read are still to come
    `WSP_ASSERT_IMPL(a_run_busy, aclk, !aresetn, m_valid && !m_data.last_of_run, !s_ready)

    // reset leaves the block idle with no result
    `WSP_ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid && s_ready)

endmodule

bind wheel_speed_period_meter wsp_checker u_checker (.*);
